// ===== rtl/clbm_pkg.sv =====
// Shared types, constants and edge arithmetic for the camera/lidar box matcher.
package clbm_pkg;

  localparam int COORD_W       = 16;
  localparam int SPAN_W        = COORD_W + 1;
  localparam int CLASS_W       = 8;
  localparam int PROB_W        = 10;
  localparam int IDX_W         = 6;
  localparam int MAX_BOXES_DEF = 64;

  // 0.4 in units of 1/1024, truncated
  localparam logic [PROB_W-1:0] THRESH_RESET = PROB_W'(409);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SPAN_W-1:0]  span_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } corners_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t hd;
  } pos_t;

  typedef struct packed {
    corners_t corners;
    pos_t     pos;
  } entry_t;

  // Query token that walks down the cell chain
  typedef struct packed {
    logic               valid;
    logic               found;
    corners_t           cam;
    span_t              w;
    span_t              h;
    logic [CLASS_W-1:0] cls;
    logic [IDX_W-1:0]   idx;
    entry_t             lid;
  } tok_t;

  // 2*|cam - lid| < span, evaluated exactly
  function automatic logic edge_close(coord_t cam, coord_t lid, span_t span);
    logic signed [SPAN_W-1:0]  d;
    logic signed [SPAN_W+1:0]  d2;
    logic signed [SPAN_W+1:0]  sp;
    d  = SPAN_W'(cam) - SPAN_W'(lid);
    d2 = (SPAN_W+2)'(d) <<< 1;
    sp = (SPAN_W+2)'(span);
    return (d2 < sp) && (d2 > -sp);
  endfunction

  // floor((a + b) / 2)
  function automatic coord_t avg_floor(coord_t a, coord_t b);
    logic signed [SPAN_W-1:0] s;
    s = SPAN_W'(a) + SPAN_W'(b);
    return coord_t'(s[SPAN_W-1:1]);
  endfunction

endpackage

// ===== rtl/clbm_cell.sv =====
// One table entry of the matcher chain: stores a lidar box and tests the passing query.
module clbm_cell #(
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                wr_en,
  input  clbm_pkg::entry_t    wr_data,
  input  clbm_pkg::tok_t      tok_i,
  input  logic [CNT_W-1:0]    rem_i,
  output clbm_pkg::tok_t      tok_o,
  output logic [CNT_W-1:0]    rem_o
);

  localparam logic [clbm_pkg::IDX_W-1:0] MY_IDX = clbm_pkg::IDX_W'(CELL_IDX);

  clbm_pkg::entry_t entry_r;
  clbm_pkg::tok_t   tok_r, tok_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             close4;
  logic             hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_data;
    end
  end

  always_comb begin
    close4 = clbm_pkg::edge_close(tok_i.cam.max_x, entry_r.corners.max_x, tok_i.w) &&
             clbm_pkg::edge_close(tok_i.cam.min_x, entry_r.corners.min_x, tok_i.w) &&
             clbm_pkg::edge_close(tok_i.cam.min_y, entry_r.corners.min_y, tok_i.h) &&
             clbm_pkg::edge_close(tok_i.cam.max_y, entry_r.corners.max_y, tok_i.h);
    // remaining count nonzero means this cell holds a live entry for the query
    hit = tok_i.valid && !tok_i.found && (rem_i != '0) && close4;
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = MY_IDX;
      tok_nxt.lid   = entry_r;
    end
    rem_nxt = (rem_i == '0) ? '0 : rem_i - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign tok_o = tok_r;
  assign rem_o = rem_r;

endmodule

// ===== rtl/camera_lidar_box_matcher_unit.sv =====
// Top level of the camera/lidar box matcher: load logic, query launch, cell chain, output.
//
//  channel | direction | handshake        | carries
//  in_     | input     | in_valid/in_stall | load of a lidar box or camera query
//  out_    | output    | out_valid/out_stall | one result per query, none per load
//  cfg_    | input     | cfg_valid/cfg_ready | probability threshold write
//
// A load does not stall the input; in_stall stays low after it.
// A query's result passes the launch register, then one register per cell of the
// chain, which holds one table entry per cell, and then the output register.
// in_stall is high while a query walks the chain; loads are taken while a
// result waits in the output register. A stalled result freezes the chain once a
// finished token reaches its end.
// Reset (synchronous) empties the table and sets the threshold to 409.
module camera_lidar_box_matcher_unit #(
  parameter int MAX_LIDAR_BOXES = clbm_pkg::MAX_BOXES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic                              in_new_list,
  input  logic signed [clbm_pkg::COORD_W-1:0] in_min_x,
  input  logic signed [clbm_pkg::COORD_W-1:0] in_min_y,
  input  logic signed [clbm_pkg::COORD_W-1:0] in_max_x,
  input  logic signed [clbm_pkg::COORD_W-1:0] in_max_y,
  input  logic signed [clbm_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [clbm_pkg::COORD_W-1:0] in_center_y,
  input  logic signed [clbm_pkg::COORD_W-1:0] in_heading,
  input  logic [clbm_pkg::CLASS_W-1:0]      in_class_id,
  input  logic [clbm_pkg::PROB_W-1:0]       in_probability,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_matched,
  output logic signed [clbm_pkg::COORD_W-1:0] out_fused_min_x,
  output logic signed [clbm_pkg::COORD_W-1:0] out_fused_min_y,
  output logic signed [clbm_pkg::COORD_W-1:0] out_fused_max_x,
  output logic signed [clbm_pkg::COORD_W-1:0] out_fused_max_y,
  output logic signed [clbm_pkg::COORD_W-1:0] out_object_center_x,
  output logic signed [clbm_pkg::COORD_W-1:0] out_object_center_y,
  output logic signed [clbm_pkg::COORD_W-1:0] out_object_heading,
  output logic [clbm_pkg::CLASS_W-1:0]      out_object_class,
  output logic [clbm_pkg::IDX_W-1:0]        out_match_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clbm_pkg::PROB_W-1:0]       cfg_data
);

  localparam int CNT_W = $clog2(MAX_LIDAR_BOXES + 1);
  localparam int WR_W  = (MAX_LIDAR_BOXES > 1) ? $clog2(MAX_LIDAR_BOXES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LIDAR_BOXES);

  logic [clbm_pkg::PROB_W-1:0] thr_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        busy_r;
  clbm_pkg::tok_t              q_r;
  logic [CNT_W-1:0]            q_rem_r;

  logic                        in_acc, acc_load, acc_query;
  logic                        wr_ok;
  logic [WR_W-1:0]             wr_idx;
  clbm_pkg::entry_t            wr_data;
  logic                        adv, fire;

  clbm_pkg::tok_t              tok_w [MAX_LIDAR_BOXES+1];
  logic [CNT_W-1:0]            rem_w [MAX_LIDAR_BOXES+1];
  clbm_pkg::tok_t              tail;

  logic                        out_valid_r;
  logic                        matched_r;
  clbm_pkg::corners_t          fused_r;
  clbm_pkg::pos_t              obj_r;
  logic [clbm_pkg::CLASS_W-1:0] cls_r;
  logic [clbm_pkg::IDX_W-1:0]  idx_r;

  assign in_acc    = in_valid && !in_stall;
  assign acc_load  = in_acc && (in_command == clbm_pkg::CMD_LOAD);
  assign acc_query = in_acc && (in_command == clbm_pkg::CMD_QUERY);
  assign in_stall  = busy_r;
  assign cfg_ready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= clbm_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // Table loading: a new list restarts at entry 0, a full table drops the load
  always_comb begin
    wr_ok     = in_new_list || (count_r < CNT_MAX);
    wr_idx    = in_new_list ? '0 : count_r[WR_W-1:0];
    count_nxt = in_new_list ? CNT_W'(1) : count_r + CNT_W'(1);
    wr_data.corners.min_x = in_min_x;
    wr_data.corners.min_y = in_min_y;
    wr_data.corners.max_x = in_max_x;
    wr_data.corners.max_y = in_max_y;
    wr_data.pos.cx        = in_center_x;
    wr_data.pos.cy        = in_center_y;
    wr_data.pos.hd        = in_heading;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc_load && wr_ok) begin
      count_r <= count_nxt;
    end
  end

  // Query launch register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= acc_query;
      if (acc_query) begin
        q_r.found     <= 1'b0;
        q_r.cam.min_x <= in_min_x;
        q_r.cam.min_y <= in_min_y;
        q_r.cam.max_x <= in_max_x;
        q_r.cam.max_y <= in_max_y;
        q_r.w         <= clbm_pkg::SPAN_W'(in_max_x) - clbm_pkg::SPAN_W'(in_min_x);
        q_r.h         <= clbm_pkg::SPAN_W'(in_max_y) - clbm_pkg::SPAN_W'(in_min_y);
        q_r.cls       <= in_class_id;
        q_r.idx       <= '0;
        q_r.lid       <= '0;
        // at or below threshold: no live entries, so nothing can match
        q_rem_r       <= (in_probability > thr_r) ? count_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (acc_query) begin
      busy_r <= 1'b1;
    end else if (fire) begin
      busy_r <= 1'b0;
    end
  end

  assign tok_w[0] = q_r;
  assign rem_w[0] = q_rem_r;
  assign tail     = tok_w[MAX_LIDAR_BOXES];

  // Chain holds while the finished token cannot leave
  assign adv  = !(tail.valid && out_valid_r && out_stall);
  assign fire = adv && tail.valid;

  for (genvar k = 0; k < MAX_LIDAR_BOXES; k++) begin : g_cell
    clbm_cell #(
      .CNT_W    (CNT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .wr_en   (acc_load && wr_ok && (wr_idx == WR_W'(k))),
      .wr_data (wr_data),
      .tok_i   (tok_w[k]),
      .rem_i   (rem_w[k]),
      .tok_o   (tok_w[k+1]),
      .rem_o   (rem_w[k+1])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      matched_r <= tail.found;
      if (tail.found) begin
        fused_r.min_x <= clbm_pkg::avg_floor(tail.cam.min_x, tail.lid.corners.min_x);
        fused_r.min_y <= clbm_pkg::avg_floor(tail.cam.min_y, tail.lid.corners.min_y);
        fused_r.max_x <= clbm_pkg::avg_floor(tail.cam.max_x, tail.lid.corners.max_x);
        fused_r.max_y <= clbm_pkg::avg_floor(tail.cam.max_y, tail.lid.corners.max_y);
        obj_r         <= tail.lid.pos;
        cls_r         <= tail.cls;
        idx_r         <= tail.idx;
      end else begin
        fused_r <= '0;
        obj_r   <= '0;
        cls_r   <= '0;
        idx_r   <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_matched         = matched_r;
  assign out_fused_min_x     = fused_r.min_x;
  assign out_fused_min_y     = fused_r.min_y;
  assign out_fused_max_x     = fused_r.max_x;
  assign out_fused_max_y     = fused_r.max_y;
  assign out_object_center_x = obj_r.cx;
  assign out_object_center_y = obj_r.cy;
  assign out_object_heading  = obj_r.hd;
  assign out_object_class    = cls_r;
  assign out_match_index     = idx_r;

endmodule

// ===== rtl/clbm_checker.sv =====
// Port-level assertions for the camera/lidar box matcher, bound to the top level.
module clbm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_command,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_matched,
  input logic signed [clbm_pkg::COORD_W-1:0] out_fused_min_x,
  input logic signed [clbm_pkg::COORD_W-1:0] out_fused_min_y,
  input logic signed [clbm_pkg::COORD_W-1:0] out_fused_max_x,
  input logic signed [clbm_pkg::COORD_W-1:0] out_fused_max_y,
  input logic signed [clbm_pkg::COORD_W-1:0] out_object_center_x,
  input logic signed [clbm_pkg::COORD_W-1:0] out_object_center_y,
  input logic signed [clbm_pkg::COORD_W-1:0] out_object_heading,
  input logic [clbm_pkg::CLASS_W-1:0]      out_object_class,
  input logic [clbm_pkg::IDX_W-1:0]        out_match_index,
  input logic                              cfg_valid,
  input logic                              cfg_ready
);

  // a stalled result keeps its matched flag, fused min x, class and match index
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched) &&
      $stable(out_fused_min_x) && $stable(out_match_index) && $stable(out_object_class))
    else $error("stalled result changed");

  // an unmatched result carries all-zero fields
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |->
      out_fused_min_x == '0 && out_fused_min_y == '0 && out_fused_max_x == '0 &&
      out_fused_max_y == '0 && out_object_center_x == '0 &&
      out_object_center_y == '0 && out_object_heading == '0 &&
      out_object_class == '0 && out_match_index == '0)
    else $error("unmatched result with nonzero fields");

  // once a query is taken, the input is stalled
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == clbm_pkg::CMD_QUERY |=> in_stall)
    else $error("input not stalled after query");

  // a load never holds the input
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == clbm_pkg::CMD_LOAD |=> !in_stall)
    else $error("input stalled after load");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("threshold write refused");

endmodule

bind camera_lidar_box_matcher_unit clbm_checker u_clbm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_command          (in_command),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_matched         (out_matched),
  .out_fused_min_x     (out_fused_min_x),
  .out_fused_min_y     (out_fused_min_y),
  .out_fused_max_x     (out_fused_max_x),
  .out_fused_max_y     (out_fused_max_y),
  .out_object_center_x (out_object_center_x),
  .out_object_center_y (out_object_center_y),
  .out_object_heading  (out_object_heading),
  .out_object_class    (out_object_class),
  .out_match_index     (out_match_index),
  .cfg_valid           (cfg_valid),
  .cfg_ready           (cfg_ready)
);
